// File: design/clws_pkg.sv
// shared types, request codes and constant tables for the character lcd write sequencer
// no dependencies; imported by clws_div10, char_lcd_write_sequencer and its testbench
package clws_pkg;

  // request codes
  localparam logic [2:0] CMD_INIT    = 3'd0;
  localparam logic [2:0] CMD_CHAR    = 3'd1;
  localparam logic [2:0] CMD_COMMAND = 3'd2;
  localparam logic [2:0] CMD_GOTO    = 3'd3;
  localparam logic [2:0] CMD_NUMBER  = 3'd4;

  // display constants
  localparam logic [7:0] DDRAM_ROW0 = 8'h80;
  localparam logic [7:0] DDRAM_ROW1 = 8'hC0;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam int unsigned MAX_DIGITS = 5;
  localparam int unsigned INIT_LEN   = 4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  byte_value;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic       reg_select;
    logic [7:0] bus_byte;
    logic [4:0] wait_before_ms;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0] quot;
    logic [3:0]  rem;
  } div_res_t;

  // power-up command sequence
  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h38;
      2'd1:    b = 8'h0C;
      2'd2:    b = 8'h01;
      default: b = 8'h06;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] init_wait(input logic [1:0] idx);
    logic [4:0] w;
    case (idx)
      2'd0:    w = 5'd31;
      2'd1:    w = 5'd1;
      2'd2:    w = 5'd1;
      default: w = 5'd2;
    endcase
    return w;
  endfunction

endpackage

// File: design/char_lcd_write_sequencer.sv
// top level of the character lcd write sequencer: request decode, digit stack and transfer output
// depends on clws_pkg and clws_div10
//
// usage
//   a request item is taken on a rising edge with start high and busy low. it turns into
//   a run of zero to five bus transfers, each shown on out_item for one cycle with
//   out_valid high; the last transfer of a run carries last_of_run.
//   write char, write command and goto give their transfer in the cycle after the
//   request and leave busy low, so a new request may follow at once.
//   init holds busy while it gives its transfers, one per cycle (waits of
//   31, 1, 1 and 2 ms ride along with the transfers).
//   write number first peels decimal digits off the value, one per cycle through a
//   single divide-by-ten unit, pushing them on a small stack; then it pops
//   them most significant first, one per cycle. busy stays high through both
//   the peeling and the popping.
//   goto outside two rows or sixteen columns, and unknown codes, give nothing.
//   reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
//   the receiver cannot hold transfers off; each is valid for exactly one cycle
module char_lcd_write_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  clws_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output clws_pkg::out_item_t  out_item
);
  import clws_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_INIT  = 2'd1;
  localparam logic [1:0] ST_CONV  = 2'd2;
  localparam logic [1:0] ST_DIGIT = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  cnt_r, cnt_nxt;       // init index or digit count
  logic [15:0] val_r, val_nxt;       // value still to be split into digits
  logic [3:0]  dig_r   [MAX_DIGITS]; // digit stack, top at entry 0
  logic [3:0]  dig_nxt [MAX_DIGITS];
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  div_res_t    div_res;
  logic        accept;

  clws_div10 u_div10 (
    .val_i (val_r),
    .res_o (div_res)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    val_nxt       = val_r;
    dig_nxt       = dig_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.cmd)
            CMD_INIT: begin
              state_nxt = ST_INIT;
              cnt_nxt   = 3'd0;
            end
            CMD_CHAR: begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{reg_select: 1'b1, bus_byte: in_item.byte_value,
                                wait_before_ms: 5'd0, last_of_run: 1'b1};
            end
            CMD_COMMAND: begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{reg_select: 1'b0, bus_byte: in_item.byte_value,
                                wait_before_ms: 5'd0, last_of_run: 1'b1};
            end
            CMD_GOTO: begin
              // only rows 0 and 1, columns 0 to 15
              if (in_item.row[7:1] == 7'd0 && in_item.column[7:4] == 4'd0) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{reg_select: 1'b0,
                                  bus_byte: (in_item.row[0] ? DDRAM_ROW1 : DDRAM_ROW0)
                                            | {4'd0, in_item.column[3:0]},
                                  wait_before_ms: 5'd0, last_of_run: 1'b1};
              end
            end
            CMD_NUMBER: begin
              state_nxt = ST_CONV;
              cnt_nxt   = 3'd0;
              val_nxt   = in_item.value;
            end
            default: begin
              // unknown request, nothing sent
            end
          endcase
        end
      end

      ST_INIT: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{reg_select: 1'b0, bus_byte: init_byte(cnt_r[1:0]),
                          wait_before_ms: init_wait(cnt_r[1:0]),
                          last_of_run: (cnt_r == 3'(INIT_LEN - 1))};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'(INIT_LEN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_CONV: begin
        // push least significant digit; zero still yields one digit
        dig_nxt[0] = div_res.rem;
        for (int i = 1; i < MAX_DIGITS; i++) begin
          dig_nxt[i] = dig_r[i-1];
        end
        val_nxt = div_res.quot;
        cnt_nxt = cnt_r + 3'd1;
        if (div_res.quot == 16'd0 || cnt_r == 3'(MAX_DIGITS - 1)) begin
          state_nxt = ST_DIGIT;
        end
      end

      ST_DIGIT: begin
        // pop most significant digit
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{reg_select: 1'b1, bus_byte: ASCII_ZERO | {4'd0, dig_r[0]},
                          wait_before_ms: 5'd0, last_of_run: (cnt_r == 3'd1)};
        for (int i = 0; i < MAX_DIGITS - 1; i++) begin
          dig_nxt[i] = dig_r[i+1];
        end
        dig_nxt[MAX_DIGITS-1] = 4'd0;
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == 3'd1) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    dig_r      <= dig_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: design/clws_div10.sv
// combinational divide-by-ten step: quotient and remainder of a 16-bit value
// depends on clws_pkg
module clws_div10 (
  input  logic [15:0]       val_i,
  output clws_pkg::div_res_t res_o
);
  import clws_pkg::*;

  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] q_times_10;
  logic [15:0] rem_full;

  // reciprocal multiply, exact for every 16-bit value
  assign prod       = {16'd0, val_i} * 32'h0000_CCCD;
  assign quot       = {3'b000, prod[31:19]};
  assign q_times_10 = {quot[12:0], 3'b000} + {quot[14:0], 1'b0};
  assign rem_full   = val_i - q_times_10;

  assign res_o.quot = quot;
  assign res_o.rem  = rem_full[3:0];

endmodule

// File: dv/char_lcd_write_sequencer_test.sv
// self-checking testbench for char_lcd_write_sequencer: drives lcd requests, predicts
// every bus transfer and compares each strobed transfer field by field
// depends on clws_pkg and the char_lcd_write_sequencer rtl
`timescale 1ns / 100ps

module char_lcd_write_sequencer_test;
  import clws_pkg::*;

  // generous ceiling: ~310 items, each with its busy time and any idle gap
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned RANDOM_ITEMS = 268;
  localparam int unsigned PHASES       = 4;
  localparam int unsigned SETTLE_CYCLES = 24;

  // scoreboard: holds the transfers still owed by accepted requests
  class lcd_transfer_board;
    out_item_t   owed_transfers[$];
    int unsigned errors;
    int unsigned transfers_checked;
    int unsigned requests_taken[8];

    function void add_transfer(logic rs, logic [7:0] b, logic [4:0] w, logic last);
      out_item_t t;
      t.reg_select     = rs;
      t.bus_byte       = b;
      t.wait_before_ms = w;
      t.last_of_run    = last;
      owed_transfers.push_back(t);
    endfunction

    // works out the transfer run that one accepted request must produce
    function void note_request(in_item_t req);
      logic [7:0]  power_up_byte [4];
      logic [4:0]  power_up_wait [4];
      logic [3:0]  digit [5];
      logic [15:0] rest;
      int          n;
      power_up_byte = '{8'h38, 8'h0C, 8'h01, 8'h06};
      power_up_wait = '{5'd31, 5'd1, 5'd1, 5'd2};
      requests_taken[req.cmd]++;
      case (req.cmd)
        CMD_INIT: begin
          for (int i = 0; i < 4; i++)
            add_transfer(1'b0, power_up_byte[i], power_up_wait[i], i == 3);
        end
        CMD_CHAR:    add_transfer(1'b1, req.byte_value, 5'd0, 1'b1);
        CMD_COMMAND: add_transfer(1'b0, req.byte_value, 5'd0, 1'b1);
        CMD_GOTO: begin
          // off-screen positions give no transfer at all
          if (req.row < 2 && req.column < 16)
            add_transfer(1'b0, (req.row == 0 ? DDRAM_ROW0 : DDRAM_ROW1) + req.column,
                         5'd0, 1'b1);
        end
        CMD_NUMBER: begin
          // peel digits least significant first, send most significant first;
          // zero still yields a single '0'
          rest = req.value;
          n = 0;
          do begin
            digit[n] = 4'(rest % 10);
            rest = rest / 10;
            n++;
          end while (rest != 0 && n < 5);
          for (int i = 0; i < n; i++)
            add_transfer(1'b1, ASCII_ZERO + digit[n - 1 - i], 5'd0, i == n - 1);
        end
        default: ;
      endcase
    endfunction

    function void report_field(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_transfer(out_item_t got);
      out_item_t want;
      if (owed_transfers.size() == 0) begin
        $display("%0t: transfer with none expected, expected nothing, got rs=%0b byte=%02h %s",
                 $time, got.reg_select, got.bus_byte, "(unrequested)");
        errors++;
        return;
      end
      want = owed_transfers.pop_front();
      transfers_checked++;
      if (got.reg_select !== want.reg_select)
        report_field("reg_select", {7'd0, want.reg_select}, {7'd0, got.reg_select});
      if (got.bus_byte !== want.bus_byte)
        report_field("bus_byte", want.bus_byte, got.bus_byte);
      if (got.wait_before_ms !== want.wait_before_ms)
        report_field("wait_before_ms", {3'd0, want.wait_before_ms},
                     {3'd0, got.wait_before_ms});
      if (got.last_of_run !== want.last_of_run)
        report_field("last_of_run", {7'd0, want.last_of_run}, {7'd0, got.last_of_run});
    endfunction

    function int unsigned outstanding();
      return owed_transfers.size();
    endfunction

    // anything still owed at the end never turned up
    function void flag_missing();
      while (owed_transfers.size() != 0) begin
        $display("%0t: missing transfer, expected byte=%02h, got nothing",
                 $time, owed_transfers[0].bus_byte);
        void'(owed_transfers.pop_front());
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;

  lcd_transfer_board board;
  int unsigned       cycle_count = 0;
  int unsigned       drain_pauses;

  char_lcd_write_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // the receiver cannot stall, so every strobed transfer is checked on the edge ending it
  always @(posedge clk) begin
    if (out_valid === 1'b1)
      board.check_transfer(out_item);
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d transfers owed", $time, board.outstanding());
      $display("status: fail");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance with start
  // still high, so a back-to-back item needs no lowering in between
  task automatic send_request(input in_item_t req);
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_request(req);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [2:0] cmd, input logic [7:0] bv,
                             input logic [7:0] row, input logic [7:0] column,
                             input logic [15:0] value);
    in_item_t req;
    req.cmd        = cmd;
    req.byte_value = bv;
    req.row        = row;
    req.column     = column;
    req.value      = value;
    send_request(req);
  endtask

  // optional idle gap of random length, so that it can land on any cycle of a number run
  task automatic maybe_rest(input int unsigned idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // sender holds off until every owed transfer has come back
  task automatic pause_until_drained();
    start <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    drain_pauses++;
  endtask

  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned pick;
    int unsigned digits;
    req.cmd        = 3'($urandom_range(0, 4));
    req.byte_value = 8'($urandom_range(0, 255));
    req.row        = 8'($urandom_range(0, 255));
    req.column     = 8'($urandom_range(0, 255));
    req.value      = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 8)       req.cmd = CMD_INIT;
    else if (pick < 26) req.cmd = CMD_CHAR;
    else if (pick < 40) req.cmd = CMD_COMMAND;
    else if (pick < 62) req.cmd = CMD_GOTO;
    else if (pick < 93) req.cmd = CMD_NUMBER;
    else                req.cmd = 3'($urandom_range(5, 7));   // unknown codes
    if (req.cmd == CMD_GOTO && $urandom_range(0, 99) < 80) begin
      // mostly on-screen positions, the rest stays fully random
      req.row    = 8'($urandom_range(0, 1));
      req.column = 8'($urandom_range(0, 15));
    end
    if (req.cmd == CMD_NUMBER) begin
      // spread over every digit count, not just five-digit values
      digits = $urandom_range(1, 5);
      case (digits)
        1:       req.value = 16'($urandom_range(0, 9));
        2:       req.value = 16'($urandom_range(10, 99));
        3:       req.value = 16'($urandom_range(100, 999));
        4:       req.value = 16'($urandom_range(1000, 9999));
        default: req.value = 16'($urandom_range(10000, 65535));
      endcase
    end
    return req;
  endfunction

  // sender idle share per phase; the receiver-stall phase has no effect here,
  // since out_valid cannot be held off, so it runs without gaps
  function automatic int unsigned idle_share(input int unsigned phase);
    case (phase)
      1:       return 45;
      3:       return 22;
      default: return 0;
    endcase
  endfunction

  initial begin
    in_item_t    req;
    int unsigned counted;
    int unsigned phase_items;
    board = new();
    drain_pauses = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: power-up, byte extremes, goto corners and off-screen, digit counts
    send_fields(CMD_INIT,    8'h5A, 8'hFF, 8'hFF, 16'hFFFF);
    send_fields(CMD_CHAR,    8'h00, 8'h00, 8'h00, 16'h0000);
    send_fields(CMD_CHAR,    8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_fields(CMD_COMMAND, 8'h00, 8'hAA, 8'h55, 16'hA5A5);
    send_fields(CMD_COMMAND, 8'hFF, 8'h55, 8'hAA, 16'h5A5A);
    send_fields(CMD_GOTO,    8'h12, 8'd0,  8'd0,  16'd0);
    send_fields(CMD_GOTO,    8'h34, 8'd0,  8'd15, 16'd0);
    send_fields(CMD_GOTO,    8'h56, 8'd1,  8'd0,  16'd0);
    send_fields(CMD_GOTO,    8'h78, 8'd1,  8'd15, 16'd0);
    send_fields(CMD_GOTO,    8'h00, 8'd2,  8'd0,  16'd0);      // row just off the bottom
    send_fields(CMD_GOTO,    8'h00, 8'd0,  8'd16, 16'd0);      // column just off the right
    send_fields(CMD_GOTO,    8'h00, 8'd255, 8'd255, 16'd0);
    send_fields(CMD_GOTO,    8'h00, 8'd1,  8'd255, 16'd0);
    send_fields(CMD_NUMBER,  8'h00, 8'h00, 8'h00, 16'd0);      // zero prints one digit
    send_fields(CMD_NUMBER,  8'h00, 8'h00, 8'h00, 16'd7);
    send_fields(CMD_NUMBER,  8'h00, 8'h00, 8'h00, 16'd10);     // trailing zero kept
    send_fields(CMD_NUMBER,  8'h00, 8'h00, 8'h00, 16'd100);
    send_fields(CMD_NUMBER,  8'h00, 8'h00, 8'h00, 16'd10000);
    send_fields(CMD_NUMBER,  8'h00, 8'h00, 8'h00, 16'd12345);
    send_fields(CMD_NUMBER,  8'hFF, 8'hFF, 8'hFF, 16'd65535);
    send_fields(3'd5,        8'hFF, 8'hFF, 8'hFF, 16'hFFFF);   // unknown codes ignored
    send_fields(3'd6,        8'h00, 8'h00, 8'h00, 16'h0000);
    send_fields(3'd7,        8'hA5, 8'h01, 8'h02, 16'h1234);
    send_fields(CMD_INIT,    8'h00, 8'h00, 8'h00, 16'h0000);

    // random phases; ignored codes do not count toward the item budget
    phase_items = RANDOM_ITEMS / PHASES;
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      counted = 0;
      while (counted < phase_items) begin
        if (counted == phase_items / 2) pause_until_drained();
        else maybe_rest(idle_share(phase));
        req = random_request();
        send_request(req);
        if (req.cmd <= CMD_NUMBER) counted++;
      end
    end

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    board.flag_missing();

    $display("run covered %0d init, %0d char, %0d command, %0d goto, %0d number requests",
             board.requests_taken[CMD_INIT], board.requests_taken[CMD_CHAR],
             board.requests_taken[CMD_COMMAND], board.requests_taken[CMD_GOTO],
             board.requests_taken[CMD_NUMBER]);
    $display("plus %0d unknown codes; %0d transfers checked, %0d drain pauses, %0d errors",
             board.requests_taken[5] + board.requests_taken[6] + board.requests_taken[7],
             board.transfers_checked, drain_pauses, board.errors);
    if (board.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
